### design/pd_controlled_pendulum_step_core_assert.svh
// Assertion macros for the pendulum step core checkers.
`ifndef PD_CONTROLLED_PENDULUM_STEP_CORE_ASSERT_SVH
`define PD_CONTROLLED_PENDULUM_STEP_CORE_ASSERT_SVH

// Same-cycle implication.
`define PDPS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdps same-cycle check failed");

// Next-cycle implication.
`define PDPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdps next-cycle check failed");

`endif

### design/pdps_pkg.sv
// Shared types, constants and saturation helpers for the pendulum step core.
package pdps_pkg;

   localparam int unsigned ADDR_W = 5;
   localparam int unsigned STEP_W = 24;
   localparam int unsigned COEF_W = 31;
   localparam int unsigned SINE_W = 16;
   localparam int unsigned OPND_W = 33;
   localparam int unsigned PROD_W = 66;
   localparam int unsigned STEP_FRAC = 24;
   localparam int unsigned SINE_FRAC = 16;

   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic [31:0] TARGET_RESET = 32'd131072;
   localparam logic [31:0] KP_RESET = 32'd655360;
   localparam logic [31:0] KD_RESET = 32'd589824000;
   localparam logic [STEP_W-1:0] STEP_RESET = 24'd16777;
   localparam logic [COEF_W-1:0] INV_INERTIA_RESET = 31'd65536;
   localparam logic [COEF_W-1:0] GRAVITY_RESET = 31'd642253;

   typedef enum logic [2:0] {
      REG_TARGET      = 3'd0,
      REG_KP          = 3'd1,
      REG_KD          = 3'd2,
      REG_STEP        = 3'd3,
      REG_INV_INERTIA = 3'd4,
      REG_GRAVITY     = 3'd5
   } reg_index_type;

   typedef enum logic {
      OP_CLOSED_LOOP = 1'b0,
      OP_EXTERNAL    = 1'b1
   } operation_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRAP,
      ST_KP,
      ST_KD,
      ST_VEL,
      ST_TQ,
      ST_SIN,
      ST_POS,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_WRAP,
      MUL_KP,
      MUL_KD,
      MUL_VEL,
      MUL_TQ,
      MUL_SIN,
      MUL_POS
   } mul_sel_type;

   typedef enum logic [2:0] {
      POST_NONE,
      POST_WRAP,
      POST_KP,
      POST_KD,
      POST_VEL,
      POST_TQ,
      POST_SIN
   } post_type;

   typedef struct packed {
      logic        load_item;
      logic        err_en;
      logic        derr_en;
      mul_sel_type mul_sel;
      post_type    post;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   typedef struct packed {
      logic signed [31:0] target;
      logic signed [31:0] kp;
      logic signed [31:0] kd;
      logic [STEP_W-1:0]  step;
      logic [COEF_W-1:0]  inv_inertia;
      logic [COEF_W-1:0]  gravity;
   } cfg_type;

   function automatic logic signed [31:0] sat_prod(input logic signed [PROD_W-1:0] v);
      logic signed [31:0] r;
      if (&v[PROD_W-1:31] || ~|v[PROD_W-1:31]) begin
         r = v[31:0];
      end else if (v[PROD_W-1]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_33(input logic [32:0] s);
      logic signed [31:0] r;
      if (s[32] == s[31]) begin
         r = s[31:0];
      end else if (s[32]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic [32:0] s;
      s = {a[31], a} + {b[31], b};
      return sat_33(s);
   endfunction

   function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic [32:0] s;
      s = {a[31], a} - {b[31], b};
      return sat_33(s);
   endfunction

endpackage

### design/pdps_csr.sv
// Configuration register file with APB-style access.
module pdps_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pdps_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output pdps_pkg::cfg_type             cfg
);
   import pdps_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type reg_index;
   logic          wr_en;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en     = psel && penable && pwrite && pready;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target      <= TARGET_RESET;
         cfg_ff.kp          <= KP_RESET;
         cfg_ff.kd          <= KD_RESET;
         cfg_ff.step        <= STEP_RESET;
         cfg_ff.inv_inertia <= INV_INERTIA_RESET;
         cfg_ff.gravity     <= GRAVITY_RESET;
      end else if (wr_en) begin
         case (reg_index)
            REG_TARGET:      cfg_ff.target      <= pwdata;
            REG_KP:          cfg_ff.kp          <= pwdata;
            REG_KD:          cfg_ff.kd          <= pwdata;
            REG_STEP:        cfg_ff.step        <= pwdata[STEP_W-1:0];
            REG_INV_INERTIA: cfg_ff.inv_inertia <= pwdata[COEF_W-1:0];
            REG_GRAVITY:     cfg_ff.gravity     <= pwdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_TARGET:      prdata = cfg_ff.target;
         REG_KP:          prdata = cfg_ff.kp;
         REG_KD:          prdata = cfg_ff.kd;
         REG_STEP:        prdata = {8'd0, cfg_ff.step};
         REG_INV_INERTIA: prdata = {1'b0, cfg_ff.inv_inertia};
         REG_GRAVITY:     prdata = {1'b0, cfg_ff.gravity};
         default:         prdata = '0;
      endcase
   end

endmodule

### design/pdps_sine_rom.sv
// Quarter-wave sine table built at elaboration, registered read.
module pdps_sine_rom #(
   parameter int unsigned SINE_TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr,
   output logic [pdps_pkg::SINE_W-1:0]         data
);
   import pdps_pkg::*;

   logic [SINE_W-1:0] rom_table [SINE_TABLE_DEPTH];
   logic [SINE_W-1:0] data_ff;

   // Taylor series to x^13 in Q2.30, rounded to Q0.16
   for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_entry
      localparam logic [63:0] X  = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      localparam logic [63:0] T1 = ((((X * X) >> 30) * X) >> 30) / 64'd6;
      localparam logic [63:0] S1 = (X >= T1) ? X - T1 : 64'd0;
      localparam logic [63:0] T2 = ((((T1 * X) >> 30) * X) >> 30) / 64'd20;
      localparam logic [63:0] S2 = S1 + T2;
      localparam logic [63:0] T3 = ((((T2 * X) >> 30) * X) >> 30) / 64'd42;
      localparam logic [63:0] S3 = (S2 >= T3) ? S2 - T3 : 64'd0;
      localparam logic [63:0] T4 = ((((T3 * X) >> 30) * X) >> 30) / 64'd72;
      localparam logic [63:0] S4 = S3 + T4;
      localparam logic [63:0] T5 = ((((T4 * X) >> 30) * X) >> 30) / 64'd110;
      localparam logic [63:0] S5 = (S4 >= T5) ? S4 - T5 : 64'd0;
      localparam logic [63:0] T6 = ((((T5 * X) >> 30) * X) >> 30) / 64'd156;
      localparam logic [63:0] S6 = S5 + T6;
      localparam logic [63:0] R  = (S6 + 64'd8192) >> 14;
      assign rom_table[i] = (R > 64'd65535) ? 16'hFFFF : R[15:0];
   end

   always_ff @(posedge clock) begin
      data_ff <= rom_table[addr];
   end

   assign data = data_ff;

endmodule

### design/pdps_datapath.sv
// Datapath: shared multiplier, saturation, joint state and result register.
module pdps_datapath #(
   parameter int unsigned SINE_TABLE_DEPTH = 256,
   parameter int unsigned FRACTION_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pdps_pkg::cfg_type     cfg,
   input  pdps_pkg::cmd_type     cmd,
   output pdps_pkg::status_type  status,
   input  logic                  req_operation,
   input  logic signed [31:0]    req_external_torque,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_position,
   output logic signed [31:0]    rsp_velocity,
   output logic signed [31:0]    rsp_acceleration,
   output logic signed [31:0]    rsp_applied_torque
);
   import pdps_pkg::*;

   localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH);

   operation_type            op_ff;
   logic signed [31:0]       ext_ff;
   logic signed [31:0]       angle_ff, vel_ff, acc_st_ff, last_err_ff;
   logic signed [31:0]       err_ff, derr_ff, kp_term_ff, torque_ff, new_vel_ff, acc_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [1:0]               quad_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     rsp_valid_ff;
   logic signed [31:0]       rsp_position_ff, rsp_velocity_ff;
   logic signed [31:0]       rsp_acceleration_ff, rsp_applied_torque_ff;

   logic signed [OPND_W-1:0] opa, opb;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] shr_frac, shr_sine, shr_step;
   logic signed [31:0]       term_frac, term_sine, term_step, new_pos;
   logic [31:0]              phase;
   logic [IDX_W+30:0]        idx_prod;
   logic [IDX_W-1:0]         rom_addr;
   logic [SINE_W-1:0]        rom_data;
   logic                     peak;
   logic signed [17:0]       sine_mag, sine_val;

   pdps_sine_rom #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_rom (
      .clock(clock),
      .addr (rom_addr),
      .data (rom_data)
   );

   assign rom_addr = quad_ff[0] ? IDX_W'(SINE_TABLE_DEPTH - idx_ff) : idx_ff;
   assign peak     = quad_ff[0] && (idx_ff == '0);
   assign sine_mag = peak ? 18'sd65536 : {2'b00, rom_data};
   assign sine_val = quad_ff[1] ? -sine_mag : sine_mag;

   always_comb begin
      opa = '0;
      opb = '0;
      case (cmd.mul_sel)
         MUL_WRAP: begin
            opa = {angle_ff[31], angle_ff};
            opb = {3'b000, INV_TWO_PI_Q32};
         end
         MUL_KP: begin
            opa = {cfg.kp[31], cfg.kp};
            opb = {err_ff[31], err_ff};
         end
         MUL_KD: begin
            opa = {cfg.kd[31], cfg.kd};
            opb = {derr_ff[31], derr_ff};
         end
         MUL_VEL: begin
            opa = {9'd0, cfg.step};
            opb = {acc_st_ff[31], acc_st_ff};
         end
         MUL_TQ: begin
            opa = {torque_ff[31], torque_ff};
            opb = {2'b00, cfg.inv_inertia};
         end
         MUL_SIN: begin
            opa = {2'b00, cfg.gravity};
            opb = {{15{sine_val[17]}}, sine_val};
         end
         MUL_POS: begin
            opa = {9'd0, cfg.step};
            opb = {vel_ff[31], vel_ff};
         end
         default: ;
      endcase
   end

   assign prod_in   = opa * opb;
   assign shr_frac  = prod_ff >>> FRACTION_BITS;
   assign shr_sine  = prod_ff >>> SINE_FRAC;
   assign shr_step  = prod_ff >>> STEP_FRAC;
   assign term_frac = sat_prod(shr_frac);
   assign term_sine = sat_prod(shr_sine);
   assign term_step = sat_prod(shr_step);
   assign phase     = shr_frac[31:0];
   assign idx_prod  = phase[29:0] * (IDX_W+1)'(SINE_TABLE_DEPTH);
   assign new_pos   = add_sat(angle_ff, term_step);

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff  <= operation_type'(req_operation);
         ext_ff <= req_external_torque;
      end
      if (cmd.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (cmd.err_en) begin
         err_ff <= sub_sat(cfg.target, angle_ff);
      end
      if (cmd.derr_en) begin
         derr_ff <= sub_sat(err_ff, last_err_ff);
      end
      case (cmd.post)
         POST_WRAP: begin
            idx_ff  <= idx_prod[IDX_W+29:30];
            quad_ff <= phase[31:30];
         end
         POST_KP:  kp_term_ff <= term_frac;
         POST_KD:  torque_ff  <= (op_ff == OP_EXTERNAL) ? ext_ff
                                                         : add_sat(kp_term_ff, term_frac);
         POST_VEL: new_vel_ff <= add_sat(vel_ff, term_step);
         POST_TQ:  acc_ff     <= term_frac;
         POST_SIN: acc_ff     <= sub_sat(acc_ff, term_sine);
         default: ;
      endcase
      if (cmd.commit) begin
         rsp_position_ff       <= new_pos;
         rsp_velocity_ff       <= new_vel_ff;
         rsp_acceleration_ff   <= acc_ff;
         rsp_applied_torque_ff <= torque_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff     <= '0;
         vel_ff       <= '0;
         acc_st_ff    <= '0;
         last_err_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            angle_ff  <= new_pos;
            vel_ff    <= new_vel_ff;
            acc_st_ff <= acc_ff;
            if (op_ff == OP_CLOSED_LOOP) begin
               last_err_ff <= err_ff;
            end
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = rsp_position_ff;
   assign rsp_velocity       = rsp_velocity_ff;
   assign rsp_acceleration   = rsp_acceleration_ff;
   assign rsp_applied_torque = rsp_applied_torque_ff;

endmodule

### design/pdps_ctrl.sv
// Controller: sequences the shared multiplier and the post-multiply updates.
module pdps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pdps_pkg::status_type status,
   output pdps_pkg::cmd_type    cmd
);
   import pdps_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_WRAP;
            end
         end
         ST_WRAP: begin
            cmd.mul_sel = MUL_WRAP;
            cmd.err_en  = 1'b1;
            state_in    = ST_KP;
         end
         ST_KP: begin
            cmd.mul_sel = MUL_KP;
            cmd.post    = POST_WRAP;
            cmd.derr_en = 1'b1;
            state_in    = ST_KD;
         end
         ST_KD: begin
            cmd.mul_sel = MUL_KD;
            cmd.post    = POST_KP;
            state_in    = ST_VEL;
         end
         ST_VEL: begin
            cmd.mul_sel = MUL_VEL;
            cmd.post    = POST_KD;
            state_in    = ST_TQ;
         end
         ST_TQ: begin
            cmd.mul_sel = MUL_TQ;
            cmd.post    = POST_VEL;
            state_in    = ST_SIN;
         end
         ST_SIN: begin
            cmd.mul_sel = MUL_SIN;
            cmd.post    = POST_TQ;
            state_in    = ST_POS;
         end
         ST_POS: begin
            cmd.mul_sel = MUL_POS;
            cmd.post    = POST_SIN;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/pd_controlled_pendulum_step_core.sv
// Top level of the PD-controlled pendulum Euler step core.
//
//   channel  dir  handshake                      word
//   req      in   req_valid / req_stall          operation, external_torque
//   rsp      out  rsp_valid / rsp_stall          position, velocity, acceleration, torque
//   csr      in   psel penable pwrite / pready   6 registers at 4*index
//
// Each item is accepted, then passes eight steps (wrap, kp, kd, velocity, torque,
// sine, position, commit); all but commit use the single shared 33x33 multiplier.
// The result register frees the input side; commit waits only while the
// previous result is still held by rsp_stall.
// Synchronous reset clears joint state and returns to idle; no clearing pass.
module pd_controlled_pendulum_step_core #(
   parameter int unsigned SINE_TABLE_DEPTH = 256,
   parameter int unsigned FRACTION_BITS    = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic signed [31:0]          req_external_torque,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [31:0]          rsp_position,
   output logic signed [31:0]          rsp_velocity,
   output logic signed [31:0]          rsp_acceleration,
   output logic signed [31:0]          rsp_applied_torque,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pdps_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import pdps_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   pdps_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg)
   );

   pdps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   pdps_datapath #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
      .FRACTION_BITS   (FRACTION_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .status             (status),
      .req_operation      (req_operation),
      .req_external_torque(req_external_torque),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position       (rsp_position),
      .rsp_velocity       (rsp_velocity),
      .rsp_acceleration   (rsp_acceleration),
      .rsp_applied_torque (rsp_applied_torque)
   );

endmodule

### design/pdps_checker.sv
// Port-level checker for the pendulum step core, bound to the top level.
`include "pd_controlled_pendulum_step_core_assert.svh"

module pdps_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);

   `PDPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `PDPS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `PDPS_ASSERT_SAME(a_new_word_idle, clock, reset, $rose(rsp_valid), !req_stall)
   `PDPS_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind pd_controlled_pendulum_step_core pdps_checker u_checker (.*);

### dv/testbench.sv
// Self-checking testbench for the PD pendulum step core: directed words, then random phases.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pdps_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int ROM_DEPTH = 256;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_WORDS = 190;
   localparam int NUM_DIRECTED = 16;
   localparam longint INV_TWO_PI_Q32 = 64'sd683565276;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] acceleration;
      logic signed [31:0] torque;
   } tick_word_type;

   typedef struct packed {
      operation_type op;
      logic [31:0]   torque;
      logic          has_want;
      tick_word_type want;
   } directed_row_type;

   typedef struct packed {
      logic [31:0] target;
      logic [31:0] kp;
      logic [31:0] kd;
      logic [31:0] step;
      logic [31:0] inv_inertia;
      logic [31:0] gravity;
   } gain_set_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   operation_type       req_operation = OP_CLOSED_LOOP;
   logic signed [31:0]  req_external_torque = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [31:0]  rsp_position;
   logic signed [31:0]  rsp_velocity;
   logic signed [31:0]  rsp_acceleration;
   logic signed [31:0]  rsp_applied_torque;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   int send_idle_pct = 13;
   int recv_stall_pct = 63;
   int mismatches = 0;

   tick_word_type pendulum_due[$];

   // pendulum state and register shadow
   longint angle_q = 0;
   longint vel_q = 0;
   longint acc_q = 0;
   longint last_err_q = 0;
   longint cfg_target = 131072;
   longint cfg_kp = 655360;
   longint cfg_kd = 589824000;
   longint cfg_step = 16777;
   longint cfg_inv = 65536;
   longint cfg_grav = 642253;
   longint unsigned sine_rom [ROM_DEPTH];

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{OP_CLOSED_LOOP, 32'h0000_0000, 1'b1,
        '{32'sd0, 32'sd0, 32'sd1180958720, 32'sd1180958720}},
      '{OP_EXTERNAL, 32'h7FFF_FFFF, 1'b1,
        '{32'sd0, 32'sd1180943, 32'sd2147483647, 32'sd2147483647}},
      '{OP_EXTERNAL, 32'h8000_0000, 1'b0, '0},
      '{OP_EXTERNAL, 32'h0000_0000, 1'b0, '0},
      '{OP_EXTERNAL, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_EXTERNAL, 32'h0000_0001, 1'b0, '0},
      '{OP_CLOSED_LOOP, 32'h0000_0000, 1'b0, '0},
      '{OP_CLOSED_LOOP, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_EXTERNAL, 32'h5555_5555, 1'b0, '0},
      '{OP_EXTERNAL, 32'hAAAA_AAAA, 1'b0, '0},
      '{OP_CLOSED_LOOP, 32'h8000_0000, 1'b0, '0},
      '{OP_CLOSED_LOOP, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_CLOSED_LOOP, 32'h0000_0000, 1'b0, '0},
      '{OP_EXTERNAL, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_EXTERNAL, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_CLOSED_LOOP, 32'h0000_0000, 1'b0, '0}
   };

   gain_set_type phase_gains [NUM_PHASES];

   pd_controlled_pendulum_step_core #(
      .SINE_TABLE_DEPTH(ROM_DEPTH),
      .FRACTION_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_external_torque(req_external_torque),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_position(rsp_position),
      .rsp_velocity(rsp_velocity),
      .rsp_acceleration(rsp_acceleration),
      .rsp_applied_torque(rsp_applied_torque),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("pd_controlled_pendulum_step_core: mismatch");
      $finish;
   end

   function automatic longint sat32(input longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   function automatic longint mul_sat(input longint a, input longint b, input int n);
      return sat32((a * b) >>> n);
   endfunction

   function automatic longint sine_q16(input longint ang);
      longint          turns;
      logic [31:0]     phase;
      longint unsigned idx;
      longint unsigned mirror;
      longint          mag;
      turns = (ang * INV_TWO_PI_Q32) >>> FRAC_BITS;
      phase = turns[31:0];
      idx = phase[29:0];
      idx = (idx * ROM_DEPTH) >> 30;
      if (phase[30]) begin
         mirror = ROM_DEPTH - idx;
         mag = (mirror >= ROM_DEPTH) ? 65536 : longint'(sine_rom[mirror]);
      end else begin
         mag = (idx < ROM_DEPTH) ? longint'(sine_rom[idx]) : 65536;
      end
      return phase[31] ? -mag : mag;
   endfunction

   function automatic tick_word_type advance_pendulum(input operation_type op,
                                                      input logic [31:0] ext);
      longint        err;
      longint        derr;
      longint        tq;
      longint        acc;
      longint        vel;
      longint        pos;
      tick_word_type w;
      if (op == OP_CLOSED_LOOP) begin
         err = sat32(cfg_target - angle_q);
         derr = sat32(err - last_err_q);
         last_err_q = err;
         tq = sat32(mul_sat(cfg_kp, err, FRAC_BITS) + mul_sat(cfg_kd, derr, FRAC_BITS));
      end else begin
         tq = longint'($signed(ext));
      end
      acc = sat32(mul_sat(tq, cfg_inv, FRAC_BITS) -
                  mul_sat(cfg_grav, sine_q16(angle_q), 16));
      vel = sat32(vel_q + mul_sat(cfg_step, acc_q, 24));
      pos = sat32(angle_q + mul_sat(cfg_step, vel_q, 24));
      angle_q = pos;
      vel_q = vel;
      acc_q = acc;
      w.position = pos[31:0];
      w.velocity = vel[31:0];
      w.acceleration = acc[31:0];
      w.torque = tq[31:0];
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s got %h want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_TARGET:      cfg_target = longint'($signed(data));
         REG_KP:          cfg_kp = longint'($signed(data));
         REG_KD:          cfg_kd = longint'($signed(data));
         REG_STEP:        cfg_step = longint'(data[23:0]);
         REG_INV_INERTIA: cfg_inv = longint'(data[30:0]);
         REG_GRAVITY:     cfg_grav = longint'(data[30:0]);
         default:         ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_gains(input gain_set_type g);
      write_csr(REG_TARGET, g.target);
      write_csr(REG_KP, g.kp);
      write_csr(REG_KD, g.kd);
      write_csr(REG_STEP, g.step);
      write_csr(REG_INV_INERTIA, g.inv_inertia);
      write_csr(REG_GRAVITY, g.gravity);
   endtask

   task automatic drain_pendulum(input int settle);
      while (pendulum_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic send_word(input operation_type op, input logic [31:0] tq,
                            input logic has_want, input tick_word_type want);
      tick_word_type w;
      req_valid <= 1'b1;
      req_operation <= op;
      req_external_torque <= tq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      w = advance_pendulum(op, tq);
      pendulum_due.push_back(has_want ? want : w);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      tick_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pendulum_due.size() == 0) begin
            report_mismatch("unexpected word, position", rsp_position, '0);
         end else begin
            want = pendulum_due.pop_front();
            if (rsp_position !== want.position)
               report_mismatch("position", rsp_position, want.position);
            if (rsp_velocity !== want.velocity)
               report_mismatch("velocity", rsp_velocity, want.velocity);
            if (rsp_acceleration !== want.acceleration)
               report_mismatch("acceleration", rsp_acceleration, want.acceleration);
            if (rsp_applied_torque !== want.torque)
               report_mismatch("applied_torque", rsp_applied_torque, want.torque);
         end
      end
   end

   initial begin
      int              i;
      int              k;
      int              p;
      int              n;
      longint unsigned x;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned v;
      operation_type   op;
      logic [31:0]     tq;

      for (i = 0; i < ROM_DEPTH; i++) begin
         x = (longint'(i) * HALF_PI_Q30) / ROM_DEPTH;
         term = x;
         sum = x;
         for (k = 1; k <= 6; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = (sum >= term) ? sum - term : 0;
            else sum = sum + term;
         end
         v = (sum + 8192) >> 14;
         if (v > 65535) v = 65535;
         sine_rom[i] = v;
      end

      phase_gains[0] = '{32'hFFFE_0000, 32'h000A_0000, 32'h0032_0000,
                         32'h0004_0000, 32'h0001_0000, 32'h0009_CCCD};
      phase_gains[1] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h00FF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      phase_gains[2] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
      phase_gains[3] = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      phase_gains[4] = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                         32'h00FF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF};
      phase_gains[5] = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      phase_gains[6] = '{32'd131072, 32'd655360, 32'd589824000,
                         32'd16777, 32'd65536, 32'd642253};
      phase_gains[7] = '{$urandom, $urandom & 32'h00FF_FFFF, $urandom & 32'h00FF_FFFF,
                         $urandom_range(0, 32'h0001_0000), $urandom, $urandom};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < NUM_DIRECTED; i++) begin
         send_word(directed_rows[i].op, directed_rows[i].torque,
                   directed_rows[i].has_want, directed_rows[i].want);
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         req_valid <= 1'b0;
         drain_pendulum(12);
         load_gains(phase_gains[p]);
         if (p < 3) begin
            send_idle_pct = 13;
            recv_stall_pct = 63;
         end else if (p < 6) begin
            send_idle_pct = 63;
            recv_stall_pct = 13;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         for (n = 0; n < PHASE_WORDS; n++) begin
            if (p == 1 && n == 95) begin
               req_valid <= 1'b0;
               drain_pendulum(0);
            end
            op = ($urandom_range(9) < 6) ? OP_CLOSED_LOOP : OP_EXTERNAL;
            case ($urandom_range(7))
               0:       tq = 32'h7FFF_FFFF;
               1:       tq = 32'h8000_0000;
               2:       tq = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
               3:       tq = $urandom & 32'h00FF_FFFF;
               default: tq = $urandom;
            endcase
            send_word(op, tq, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      drain_pendulum(20);
      if (mismatches == 0) begin
         $display("pd_controlled_pendulum_step_core: match");
      end else begin
         $display("pd_controlled_pendulum_step_core: mismatch");
      end
      $finish;
   end
endmodule

### sim.f
+incdir+design
design/pdps_pkg.sv
design/pdps_csr.sv
design/pdps_sine_rom.sv
design/pdps_datapath.sv
design/pdps_ctrl.sv
design/pd_controlled_pendulum_step_core.sv
design/pdps_checker.sv
dv/testbench.sv
